[hdl/battery_charge_state_inference_defines.svh]
// Assertion macros shared by the battery charge state inference RTL.
// No dependencies; each user must have clk and rst_n in scope.
`ifndef BATTERY_CHARGE_STATE_INFERENCE_DEFINES_SVH
`define BATTERY_CHARGE_STATE_INFERENCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BCSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BCSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bcsi_pkg.sv]
// Package for the battery charge state inference block: widths, codes,
// reset values and shared types. No dependencies.
`default_nettype none

package bcsi_pkg;

  // Window depth default
  localparam int HISTORY_DEPTH_DEF = 16;

  // Field widths
  localparam int V_W        = 14;
  localparam int PC_W       = 8;
  localparam int T_W        = 48;
  localparam int SLOPE_W    = 19;
  localparam int LVL_W      = 8;
  localparam int THR_W      = 16;
  localparam int PER_W      = 12;
  localparam int TMO_W      = 17;
  localparam int TMO_US_W   = 37;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Arithmetic constants
  localparam int S_PER_MIN     = 60;
  localparam int US_PER_S      = 1000000;
  localparam int SLOPE_MAX     = 262143;
  localparam int SLOPE_MIN_MAG = 262144;
  localparam logic signed [SLOPE_W-1:0] SLOPE_MAX_VAL = SLOPE_W'(SLOPE_MAX);
  localparam logic signed [SLOPE_W-1:0] SLOPE_MIN_VAL = {1'b1, {(SLOPE_W-1){1'b0}}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_VOLTAGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_THR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_THR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TMO     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_LEVEL   = 3'd5;

  // Configuration reset values
  localparam logic [V_W-1:0]   FULL_VOLTAGE_RST = 14'd4200;
  localparam logic [THR_W-1:0] RISE_THR_RST     = 16'd3;
  localparam logic [THR_W-1:0] FALL_THR_RST     = 16'd3;
  localparam logic [PER_W-1:0] PERIOD_RST       = 12'd30;
  localparam logic [TMO_W-1:0] IDLE_TMO_RST     = 17'd60;
  localparam logic [LVL_W-1:0] WAKE_LEVEL_RST   = 8'd255;

  // Item kinds
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_KEY    = 1'b1;

  typedef enum logic [1:0] {
    MODE_UNKNOWN  = 2'd0,
    MODE_CHARGING = 2'd1,
    MODE_BATTERY  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_WALK,
    S_DIV,
    S_DECIDE
  } state_t;

  // Control from the sequencer to the window store
  typedef struct packed {
    logic wr_en;
    logic start;
  } win_ctl_t;

endpackage

`default_nettype wire

[hdl/bcsi_if.sv]
// Valid/ready channel interfaces for the input items and the result items.
// Depends on bcsi_pkg.
`default_nettype none

interface bcsi_in_if;
  import bcsi_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [V_W-1:0]         voltage_mv;
  logic signed [PC_W-1:0] charge_percent;
  logic [T_W-1:0]         time_us;

  modport source (output valid, func, voltage_mv, charge_percent, time_us, input ready);
  modport sink   (input valid, func, voltage_mv, charge_percent, time_us, output ready);
endinterface

interface bcsi_out_if #(
  parameter int HISTORY_DEPTH = bcsi_pkg::HISTORY_DEPTH_DEF
);
  import bcsi_pkg::*;

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  logic                      valid;
  logic                      ready;
  logic [1:0]                power_mode;
  logic signed [SLOPE_W-1:0] slope_mv_per_min;
  logic [V_W-1:0]            latest_mv;
  logic signed [PC_W-1:0]    latest_percent;
  logic [CNT_W-1:0]          sample_count;
  logic                      screen_is_off;
  logic                      backlight_write;
  logic [LVL_W-1:0]          backlight_level;
  logic                      key_swallowed;

  modport source (output valid, power_mode, slope_mv_per_min, latest_mv, latest_percent,
                  sample_count, screen_is_off, backlight_write, backlight_level,
                  key_swallowed, input ready);
  modport sink   (input valid, power_mode, slope_mv_per_min, latest_mv, latest_percent,
                  sample_count, screen_is_off, backlight_write, backlight_level,
                  key_swallowed, output ready);
endinterface

`default_nettype wire

[hdl/bcsi_window.sv]
// Voltage window store (synchronous RAM, registered read) and the walk that
// accumulates the least-squares numerator and denominator. Depends on bcsi_pkg.
`default_nettype none

module bcsi_window #(
  parameter int HISTORY_DEPTH = bcsi_pkg::HISTORY_DEPTH_DEF,
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1,
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1),
  localparam int XP_W  = CNT_W + 1,
  localparam int NUM_W = XP_W + bcsi_pkg::V_W + 1 + CNT_W,
  localparam int DEN_W = 2 * XP_W + CNT_W
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire bcsi_pkg::win_ctl_t       ctl,
  input  wire logic [IDX_W-1:0]         wr_addr,
  input  wire logic [bcsi_pkg::V_W-1:0] wr_data,
  input  wire logic [IDX_W-1:0]         rd_base,
  input  wire logic [CNT_W-1:0]         rd_count,
  output logic                          done,
  output logic signed [NUM_W-1:0]       num,
  output logic [DEN_W-1:0]              den
);
  import bcsi_pkg::*;

  logic [V_W-1:0]          mem [HISTORY_DEPTH];
  logic [V_W-1:0]          rd_data_r;
  logic [IDX_W-1:0]        rd_addr_r;
  logic [CNT_W-1:0]        left_r;
  logic                    walk_r;
  logic                    vld_d_r;
  logic signed [XP_W-1:0]  xp_r;
  logic signed [XP_W-1:0]  xp_d_r;
  logic signed [NUM_W-1:0] num_r;
  logic [DEN_W-1:0]        den_r;

  logic                    issue;
  logic [IDX_W-1:0]        addr_next;
  logic signed [XP_W+V_W:0] prod;
  logic signed [2*XP_W-1:0] sq;
  logic signed [XP_W-1:0]  xp_init;

  // RAM write port: new samples land at the head
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // RAM read port, data registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr_r];
  end

  assign issue     = walk_r && (left_r != '0);
  assign done      = walk_r && (left_r == '0) && !vld_d_r;
  assign addr_next = (rd_addr_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : rd_addr_r + 1'b1;
  // centered abscissa starts at -(n-1) and steps by two
  assign xp_init   = $signed(XP_W'(1)) - $signed({1'b0, rd_count});
  assign prod      = xp_d_r * $signed({1'b0, rd_data_r});
  assign sq        = xp_d_r * xp_d_r;

  // Walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r  <= 1'b0;
      left_r  <= '0;
      vld_d_r <= 1'b0;
    end else if (ctl.start) begin
      walk_r  <= 1'b1;
      left_r  <= rd_count;
      vld_d_r <= 1'b0;
    end else begin
      vld_d_r <= issue;
      if (issue) begin
        left_r <= left_r - 1'b1;
      end
      if (done) begin
        walk_r <= 1'b0;
      end
    end
  end

  // Address walk and accumulation, one entry per cycle
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rd_addr_r <= rd_base;
      xp_r      <= xp_init;
      num_r     <= '0;
      den_r     <= '0;
    end else begin
      if (issue) begin
        rd_addr_r <= addr_next;
        xp_r      <= xp_r + $signed(XP_W'(2));
        xp_d_r    <= xp_r;
      end
      if (vld_d_r) begin
        num_r <= num_r + NUM_W'(prod);
        den_r <= den_r + DEN_W'($unsigned(sq));
      end
    end
  end

  assign num = num_r;
  assign den = den_r;

endmodule

`default_nettype wire

[hdl/bcsi_div.sv]
// Slope divider: scales the numerator by 60, divides by 2*den*period one
// quotient bit per cycle, truncates toward zero and saturates. Depends on bcsi_pkg.
`default_nettype none

module bcsi_div #(
  parameter int HISTORY_DEPTH = bcsi_pkg::HISTORY_DEPTH_DEF,
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1),
  localparam int XP_W  = CNT_W + 1,
  localparam int NUM_W = XP_W + bcsi_pkg::V_W + 1 + CNT_W,
  localparam int DEN_W = 2 * XP_W + CNT_W
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [NUM_W-1:0]             num,
  input  wire logic [DEN_W-1:0]                    den,
  input  wire logic [bcsi_pkg::PER_W-1:0]          period,
  output logic                                     done,
  output logic signed [bcsi_pkg::SLOPE_W-1:0]      quot
);
  import bcsi_pkg::*;

  localparam int DVD_W = NUM_W + 6;
  localparam int DP_W  = DEN_W + PER_W;
  localparam int DSR_W = DP_W + 1;
  localparam int ITR_W = $clog2(DVD_W + 1);

  logic                      run_r;
  logic                      done_r;
  logic [ITR_W-1:0]          cnt_r;
  logic                      neg_r;
  logic [DVD_W-1:0]          quo_r;
  logic [DSR_W-1:0]          rem_r;
  logic [DSR_W-1:0]          dsr_r;
  logic signed [SLOPE_W-1:0] quot_r;

  logic [NUM_W-1:0]          mag;
  logic [DVD_W-1:0]          dvd_init;
  logic [PER_W-1:0]          per_eff;
  logic [DP_W-1:0]           dp;
  logic [DSR_W:0]            rem_sh;
  logic                      ge;
  logic signed [SLOPE_W-1:0] qsat;

  // Operand setup: magnitude times 60, divisor 2*den*period
  assign mag      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign dvd_init = DVD_W'(mag) * DVD_W'(S_PER_MIN);
  assign per_eff  = (period == '0) ? PER_W'(1) : period;
  assign dp       = DP_W'(den) * DP_W'(per_eff);

  // Restoring step
  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  // Sign and saturation of the truncated quotient
  always_comb begin
    if (!neg_r) begin
      qsat = (quo_r > DVD_W'(SLOPE_MAX)) ? SLOPE_MAX_VAL : $signed(quo_r[SLOPE_W-1:0]);
    end else begin
      qsat = (quo_r > DVD_W'(SLOPE_MIN_MAG)) ? SLOPE_MIN_VAL
                                              : -$signed(quo_r[SLOPE_W-1:0]);
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= ITR_W'(DVD_W);
      end else if (run_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - 1'b1;
        end else begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NUM_W-1];
      quo_r <= dvd_init;
      rem_r <= '0;
      dsr_r <= {dp, 1'b0};
    end else if (run_r) begin
      if (cnt_r != '0) begin
        quo_r <= {quo_r[DVD_W-2:0], ge};
        rem_r <= ge ? DSR_W'(rem_sh - {1'b0, dsr_r}) : DSR_W'(rem_sh);
      end else begin
        quot_r <= qsat;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

[hdl/battery_charge_state_inference.sv]
// Battery charge state inference, top level: configuration, sequencer,
// power mode decision and screen-off machine. Depends on bcsi_pkg, bcsi_if,
// bcsi_window, bcsi_div and battery_charge_state_inference_defines.svh.
//
// Usage:
//   in_ch carries one item per transfer: a battery sample (func 0) or a key
//   press (func 1). out_ch returns exactly one result per item, in order.
//   cfg_wr_en/cfg_index/cfg_wdata write a configuration register;
//   write only while no item is in flight.
// Order of work (one item at a time):
//   Key items and samples with fewer than two readings go from the input
//   transfer through S_PREP and S_DECIDE to the output register.
//   Samples with n >= 2 readings also pass S_WALK and S_DIV: the walk reads
//   one window entry per cycle and the divider takes one quotient bit per
//   cycle (32 bits at depth 16).
//   in_ch.ready is high only in idle, from the cycle after a result is loaded.
// Reset: synchronous, active low; window empty, mode unknown, screen on,
//   configuration back to its defaults. The window RAM is not cleared.
// Stall: a finished result sits in the output register; the next item is
//   accepted meanwhile, and its result waits until out_ch.ready takes the first.
`default_nettype none
`include "battery_charge_state_inference_defines.svh"

module battery_charge_state_inference #(
  parameter int HISTORY_DEPTH = bcsi_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  bcsi_in_if.sink                            in_ch,
  bcsi_out_if.source                         out_ch,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bcsi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcsi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bcsi_pkg::*;

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int XP_W  = CNT_W + 1;
  localparam int NUM_W = XP_W + V_W + 1 + CNT_W;
  localparam int DEN_W = 2 * XP_W + CNT_W;
  localparam int DIF_W = T_W + 1;

  // Configuration registers
  logic [V_W-1:0]   full_v_r;
  logic [THR_W-1:0] rise_r;
  logic [THR_W-1:0] fall_r;
  logic [PER_W-1:0] period_r;
  logic [TMO_W-1:0] tmo_r;
  logic [LVL_W-1:0] wake_r;
  logic [TMO_US_W-1:0] tmo_us_r;

  // Block state
  state_t                    state_r, state_nxt;
  logic                      func_r;
  logic [T_W-1:0]            time_r;
  logic [IDX_W-1:0]          head_r;
  logic [CNT_W-1:0]          fill_r;
  logic [V_W-1:0]            last_mv_r;
  logic signed [PC_W-1:0]    last_pc_r;
  mode_t                     mode_r;
  logic signed [SLOPE_W-1:0] slope_r;
  logic [T_W-1:0]            last_key_r;
  logic                      blanked_r;
  logic                      idle_r;

  // Output register
  logic                      out_valid_r;
  mode_t                     out_mode_r;
  logic signed [SLOPE_W-1:0] out_slope_r;
  logic [V_W-1:0]            out_mv_r;
  logic signed [PC_W-1:0]    out_pc_r;
  logic [CNT_W-1:0]          out_count_r;
  logic                      out_off_r;
  logic                      out_blw_r;
  logic [LVL_W-1:0]          out_lvl_r;
  logic                      out_swl_r;

  // Sequencer outputs
  logic     in_rdy;
  logic     accept;
  logic     div_start;
  logic     out_load;
  win_ctl_t win_ctl;

  logic                      win_done;
  logic signed [NUM_W-1:0]   win_num;
  logic [DEN_W-1:0]          win_den;
  logic                      div_done;
  logic signed [SLOPE_W-1:0] div_q;

  logic [SUM_W-1:0]          st_sum;
  logic [IDX_W-1:0]          st_addr;
  logic                      few;
  logic signed [DIF_W-1:0]   dt;
  logic signed [SLOPE_W:0]   slope_x;
  logic                      rise_ok;
  logic                      fall_ok;
  mode_t                     mode_calc;
  mode_t                     mode_new;
  logic                      blank_new;
  logic                      blw;
  logic [LVL_W-1:0]          lvl;
  logic                      swl;

  assign accept = in_ch.valid && in_rdy;
  assign few    = fill_r < CNT_W'(2);

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_v_r <= FULL_VOLTAGE_RST;
      rise_r   <= RISE_THR_RST;
      fall_r   <= FALL_THR_RST;
      period_r <= PERIOD_RST;
      tmo_r    <= IDLE_TMO_RST;
      wake_r   <= WAKE_LEVEL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FULL_VOLTAGE: full_v_r <= cfg_wdata[V_W-1:0];
        CFG_RISE_THR:     rise_r   <= cfg_wdata[THR_W-1:0];
        CFG_FALL_THR:     fall_r   <= cfg_wdata[THR_W-1:0];
        CFG_PERIOD:       period_r <= cfg_wdata[PER_W-1:0];
        CFG_IDLE_TMO:     tmo_r    <= cfg_wdata[TMO_W-1:0];
        CFG_WAKE_LEVEL:   wake_r   <= cfg_wdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Idle timeout in microseconds and the idle test, both registered
  assign dt = $signed({1'b0, time_r}) - $signed({1'b0, last_key_r});
  always_ff @(posedge clk) begin
    tmo_us_r <= TMO_US_W'(tmo_r) * TMO_US_W'(US_PER_S);
    idle_r   <= dt >= $signed(DIF_W'(tmo_us_r));
  end

  // Oldest entry of the window
  assign st_sum  = SUM_W'(head_r) + SUM_W'(HISTORY_DEPTH) - SUM_W'(fill_r);
  assign st_addr = (st_sum >= SUM_W'(HISTORY_DEPTH)) ? IDX_W'(st_sum - SUM_W'(HISTORY_DEPTH))
                                                     : IDX_W'(st_sum);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    in_rdy        = 1'b0;
    win_ctl.start = 1'b0;
    win_ctl.wr_en = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_rdy        = 1'b1;
        win_ctl.wr_en = in_ch.valid && (in_ch.func == FUNC_SAMPLE) && (in_ch.voltage_mv != '0);
        if (in_ch.valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (func_r == FUNC_KEY || few) begin
          state_nxt = S_DECIDE;
        end else begin
          win_ctl.start = 1'b1;
          state_nxt     = S_WALK;
        end
      end
      S_WALK: begin
        if (win_done) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Power mode decision from the fresh slope
  assign slope_x = {slope_r[SLOPE_W-1], slope_r};
  assign rise_ok = slope_x >= $signed({4'b0, rise_r});
  assign fall_ok = slope_x <= -$signed({4'b0, fall_r});

  always_comb begin
    if (few) begin
      mode_calc = MODE_UNKNOWN;
    end else if (last_mv_r >= full_v_r) begin
      mode_calc = MODE_CHARGING;
    end else if (rise_ok) begin
      mode_calc = MODE_CHARGING;
    end else if (fall_ok) begin
      mode_calc = MODE_BATTERY;
    end else begin
      mode_calc = mode_r;
    end
  end

  // Screen-off machine
  always_comb begin
    mode_new  = mode_r;
    blank_new = blanked_r;
    blw       = 1'b0;
    lvl       = '0;
    swl       = 1'b0;
    if (func_r == FUNC_SAMPLE) begin
      mode_new = mode_calc;
      if (!blanked_r && idle_r && mode_calc == MODE_BATTERY) begin
        blw       = 1'b1;
        blank_new = 1'b1;
      end else if (blanked_r && mode_calc != MODE_BATTERY) begin
        blw       = 1'b1;
        lvl       = wake_r;
        blank_new = 1'b0;
      end
    end else if (blanked_r) begin
      blw       = 1'b1;
      lvl       = wake_r;
      blank_new = 1'b0;
      swl       = 1'b1;
    end
  end

  // Block state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      fill_r     <= '0;
      last_mv_r  <= '0;
      last_pc_r  <= '1;
      mode_r     <= MODE_UNKNOWN;
      slope_r    <= '0;
      last_key_r <= '0;
      blanked_r  <= 1'b0;
    end else begin
      if (win_ctl.wr_en) begin
        head_r    <= (head_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : head_r + 1'b1;
        last_mv_r <= in_ch.voltage_mv;
        if (fill_r < CNT_W'(HISTORY_DEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (accept && in_ch.func == FUNC_SAMPLE && !in_ch.charge_percent[PC_W-1]) begin
        last_pc_r <= in_ch.charge_percent;
      end
      if (state_r == S_PREP && func_r == FUNC_SAMPLE && few) begin
        slope_r <= '0;
      end
      if (state_r == S_DIV && div_done) begin
        slope_r <= div_q;
      end
      if (out_load) begin
        mode_r    <= mode_new;
        blanked_r <= blank_new;
        if (func_r == FUNC_KEY) begin
          last_key_r <= time_r;
        end
      end
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_ch.func;
      time_r <= in_ch.time_us;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mode_r  <= mode_new;
      out_slope_r <= slope_r;
      out_mv_r    <= last_mv_r;
      out_pc_r    <= last_pc_r;
      out_count_r <= fill_r;
      out_off_r   <= blank_new;
      out_blw_r   <= blw;
      out_lvl_r   <= lvl;
      out_swl_r   <= swl;
    end
  end

  assign in_ch.ready             = in_rdy;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.power_mode       = out_mode_r;
  assign out_ch.slope_mv_per_min = out_slope_r;
  assign out_ch.latest_mv        = out_mv_r;
  assign out_ch.latest_percent   = out_pc_r;
  assign out_ch.sample_count     = out_count_r;
  assign out_ch.screen_is_off    = out_off_r;
  assign out_ch.backlight_write  = out_blw_r;
  assign out_ch.backlight_level  = out_lvl_r;
  assign out_ch.key_swallowed    = out_swl_r;

  // Window store and walk
  bcsi_window #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (win_ctl),
    .wr_addr  (head_r),
    .wr_data  (in_ch.voltage_mv),
    .rd_base  (st_addr),
    .rd_count (fill_r),
    .done     (win_done),
    .num      (win_num),
    .den      (win_den)
  );

  // Slope divider
  bcsi_div #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (win_num),
    .den    (win_den),
    .period (period_r),
    .done   (div_done),
    .quot   (div_q)
  );

  // Checks
  `BCSI_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CNT_W'(HISTORY_DEPTH), "window fill beyond depth")
  `BCSI_ASSERT_NEXT(a_one_item, accept, !in_ch.ready, "second item taken while one is in work")
  `BCSI_ASSERT_NOW(a_walk_done, win_done, state_r == S_WALK, "window walk ended outside walk phase")
  `BCSI_ASSERT_NOW(a_div_done, div_done, state_r == S_DIV, "divider finished outside divide phase")
  `BCSI_ASSERT_NOW(a_blank_level, out_valid_r && out_blw_r && out_off_r, out_lvl_r == '0,
    "blanking command with nonzero level")
  `BCSI_ASSERT_NOW(a_few_unknown, out_valid_r && out_count_r < CNT_W'(2),
    out_mode_r == MODE_UNKNOWN, "known mode with fewer than two samples")

endmodule

`default_nettype wire
